@@ hw/rtl/amat_pkg.sv @@
// amat_pkg: shared constants and the cordic arctangent table
// used by the accel moving average tilt core and its sub-units
`timescale 1ns / 1ps
package amat_pkg;
    localparam int WINDOW_DEF       = 16;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ANGLE_BITS       = 15;
    localparam int AVG_BITS         = 16;
    localparam int HALF_TURN        = 11520;
    localparam int CW               = 36;
    localparam int ZW               = 28;

    function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
        logic [ZW-1:0] v;
        begin
            case (i)
                5'd0: v = 28'd2949120;
                5'd1: v = 28'd1740967;
                5'd2: v = 28'd919879;
                5'd3: v = 28'd466945;
                5'd4: v = 28'd234379;
                5'd5: v = 28'd117304;
                5'd6: v = 28'd58666;
                5'd7: v = 28'd29335;
                5'd8: v = 28'd14668;
                5'd9: v = 28'd7334;
                5'd10: v = 28'd3667;
                5'd11: v = 28'd1833;
                5'd12: v = 28'd917;
                5'd13: v = 28'd458;
                5'd14: v = 28'd229;
                5'd15: v = 28'd115;
                5'd16: v = 28'd57;
                5'd17: v = 28'd29;
                5'd18: v = 28'd14;
                5'd19: v = 28'd7;
                5'd20: v = 28'd4;
                5'd21: v = 28'd2;
                5'd22: v = 28'd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction
endpackage

@@ hw/rtl/amat_divider.sv @@
// amat_divider: restoring shift-subtract divider, one quotient bit per cycle
// signed sum by unsigned count, truncated toward zero; depends on amat_pkg
`timescale 1ns / 1ps
module amat_divider
    import amat_pkg::*;
#(
    parameter int NUM_BITS = 24,
    parameter int DEN_BITS = 9
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] num,
    input  logic        [DEN_BITS-1:0] den,
    output logic                       done,
    output logic signed [NUM_BITS-1:0] quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg;
    logic                neg_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
        if (busy_reg)
        begin
            q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= busy_reg && (cnt_reg == CNT_BITS'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NUM_BITS-1] ? NUM_BITS'(-num) : num;
            r_reg   <= '0;
            d_reg   <= den;
            neg_reg <= num[NUM_BITS-1];
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quo = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

@@ hw/rtl/amat_cordic.sv @@
// amat_cordic: vectoring cordic, one micro-rotation per cycle
// gives atan2(n, d) in 1/64 degree; depends on amat_pkg
`timescale 1ns / 1ps
module amat_cordic
    import amat_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [AVG_BITS-1:0]   num,
    input  logic signed [AVG_BITS-1:0]   den,
    output logic                         done,
    output logic signed [ANGLE_BITS-1:0] angle
);
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SHIFT = 32 - SAMPLE_BITS;

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           i_reg;
    logic                 busy_reg;
    logic                 zero_reg;
    logic signed [ANGLE_BITS-1:0] zero_ang_reg;
    logic signed [CW-1:0] xs, ys, x0, y0;
    logic signed [ZW-1:0] r;
    logic signed [ZW-1:0] res_next;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign x0 = CW'(den) <<< SHIFT;
    assign y0 = CW'(num) <<< SHIFT;
    assign r  = (z_reg + ZW'(512)) >>> 10;

    always_comb
    begin
        if (r > ZW'(HALF_TURN))
            res_next = ZW'(HALF_TURN);
        else if (r < -ZW'(HALF_TURN))
            res_next = -ZW'(HALF_TURN);
        else
            res_next = r;
    end

    assign angle = zero_reg ? zero_ang_reg : ANGLE_BITS'(res_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                i_reg <= '0;
                if (num == '0)
                    done <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == 5'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg     <= (num == '0);
            zero_ang_reg <= den[AVG_BITS-1] ? ANGLE_BITS'(HALF_TURN) : '0;
            if (den[AVG_BITS-1])
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= num[AVG_BITS-1] ? -ZW'(180 * 65536) : ZW'(180 * 65536);
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[CW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + $signed(atan_entry(i_reg));
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - $signed(atan_entry(i_reg));
            end
        end
    end
endmodule

@@ hw/rtl/accel_moving_average_tilt_core.sv @@
// accel_moving_average_tilt_core: three-axis moving average with tilt angles
// a zero numerator skips its cordic pass and gives 0 or a half turn by the sign of the denominator
// one transaction at a time: no new sample is taken until out_ready accepts the result
// rst_n clears fill count, write position and sums; window memory is not cleared
// uses amat_pkg, amat_divider, amat_cordic
`timescale 1ns / 1ps
module accel_moving_average_tilt_core
    import amat_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_BITS-1:0] x_sample,
    input  logic signed [SAMPLE_BITS-1:0] y_sample,
    input  logic signed [SAMPLE_BITS-1:0] z_sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [AVG_BITS-1:0]   x_average,
    output logic signed [AVG_BITS-1:0]   y_average,
    output logic signed [AVG_BITS-1:0]   z_average,
    output logic signed [ANGLE_BITS-1:0] roll_angle,
    output logic signed [ANGLE_BITS-1:0] pitch_angle,
    output logic [4:0]                   samples_held
);
    localparam int PB = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FB = $clog2(WINDOW + 1);
    localparam int SB = SAMPLE_BITS + FB + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ROLL  = 3'd4;
    localparam logic [2:0] S_PITCH = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [3*SAMPLE_BITS-1:0] mem [WINDOW];
    logic [3*SAMPLE_BITS-1:0] old_reg, new_reg;
    logic [PB-1:0] pos_reg;
    logic [FB-1:0] fill_reg;
    logic          full_reg;
    logic signed [SB-1:0] sum_reg [3];
    logic signed [AVG_BITS-1:0] avg_reg [3];
    logic [2:0] div_done;
    logic signed [SB-1:0] quo [3];
    logic div_start, cor_start, cor_done;
    logic signed [AVG_BITS-1:0] cor_num;
    logic signed [ANGLE_BITS-1:0] cor_angle;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign div_start = (state_reg == S_SUM);
    assign cor_num   = (state_reg == S_PITCH) ? avg_reg[1] : avg_reg[0];

    for (genvar a = 0; a < 3; a++)
    begin : g_div
        amat_divider #(.NUM_BITS(SB), .DEN_BITS(FB)) u_div (
            .clk(clk), .rst_n(rst_n), .start(div_start),
            .num(sum_reg[a]), .den(fill_reg),
            .done(div_done[a]), .quo(quo[a])
        );
    end

    amat_cordic #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cor_start), .num(cor_num),
        .den(avg_reg[2]), .done(cor_done), .angle(cor_angle)
    );

    logic started_reg;
    assign cor_start = ((state_reg == S_ROLL) || (state_reg == S_PITCH)) && !started_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem[pos_reg] <= {z_sample, y_sample, x_sample};
            old_reg      <= mem[pos_reg];
            new_reg      <= {z_sample, y_sample, x_sample};
        end
        if (state_reg == S_DIV && div_done[0])
            for (int a = 0; a < 3; a++)
                avg_reg[a] <= AVG_BITS'(quo[a]);
        if (state_reg == S_ROLL && cor_done)
            roll_angle <= cor_angle;
        if (state_reg == S_PITCH && cor_done)
            pitch_angle <= cor_angle;
    end

    assign x_average    = avg_reg[0];
    assign y_average    = avg_reg[1];
    assign z_average    = avg_reg[2];
    assign samples_held = 5'(fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            fill_reg    <= '0;
            full_reg    <= 1'b0;
            started_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
                sum_reg[a] <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        full_reg <= (fill_reg == FB'(WINDOW));
                        if (fill_reg != FB'(WINDOW))
                            fill_reg <= fill_reg + 1'b1;
                        pos_reg <= (pos_reg == PB'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    for (int a = 0; a < 3; a++)
                        sum_reg[a] <= sum_reg[a]
                            + SB'($signed(new_reg[a*SAMPLE_BITS +: SAMPLE_BITS]))
                            - (full_reg ? SB'($signed(old_reg[a*SAMPLE_BITS +: SAMPLE_BITS]))
                                        : SB'(0));
                    state_reg <= S_SUM;
                end
                S_SUM:   state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done[0])
                        state_reg <= S_ROLL;
                end
                S_ROLL, S_PITCH:
                begin
                    if (cor_done && started_reg)
                    begin
                        started_reg <= 1'b0;
                        state_reg   <= (state_reg == S_ROLL) ? S_PITCH : S_OUT;
                    end
                    else
                    begin
                        started_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/amat_checker.sv @@
// amat_checker: port-level assertions for accel_moving_average_tilt_core
// bound to the top level; depends on amat_pkg
`timescale 1ns / 1ps
module amat_checker
    import amat_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [4:0]                   samples_held,
    input logic signed [ANGLE_BITS-1:0] roll_angle
);
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(samples_held))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> samples_held != 5'd0)
        else $error("empty window on output");
    a_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll_angle <= ANGLE_BITS'(HALF_TURN) && roll_angle >= -ANGLE_BITS'(HALF_TURN))
        else $error("angle out of range");
endmodule

bind accel_moving_average_tilt_core amat_checker u_amat_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .samples_held(samples_held), .roll_angle(roll_angle)
);
